// File: hdl/loq_pkg.sv
// Shared widths, codes and interface types of the line octant setup and query core.
package loq_pkg;

   // Coordinate width of the endpoints, queries and results.
   localparam int CW = 16;
   // Widths derived from the coordinate width.
   localparam int TW  = CW + 2;          // minor offset of a query
   localparam int AW  = CW + 4;          // signed multiplicand and quotient
   localparam int BW  = CW + 1;          // unsigned multiplier (a line delta)
   localparam int PW  = AW + 1 + BW;     // product
   localparam int NW  = PW + 2;          // dividend
   localparam int DW  = CW + 2;          // divisor (twice a delta)
   localparam int MCW = $clog2(BW);
   localparam int DCW = $clog2(NW);

   localparam logic [1:0] KIND_MINOR = 2'd0;
   localparam logic [1:0] KIND_MAJOR = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] REG_START_X = 2'd0;
   localparam logic [1:0] REG_START_Y = 2'd1;
   localparam logic [1:0] REG_END_X   = 2'd2;
   localparam logic [1:0] REG_END_Y   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_SETUP_OFF,
      PH_MINOR_OFF,
      PH_MAJ_EST,
      PH_MAJ_CHECK,
      PH_MAJ_BACK,
      PH_ERR_OFF,
      PH_ERR_MUL
   } phase_type;

   typedef struct packed {
      logic                 start;
      logic signed [AW-1:0] a;
      logic [BW-1:0]        b;
   } mul_req_type;

   typedef struct packed {
      logic                 done;
      logic signed [PW-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic                 start;
      logic                 ceil;
      logic signed [NW-1:0] numer;
      logic [DW-1:0]        denom;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic signed [AW-1:0] quot;
   } div_rsp_type;

endpackage

// File: hdl/loq_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand by an unsigned delta.
module loq_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  loq_pkg::mul_req_type req,
   output loq_pkg::mul_rsp_type rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [loq_pkg::MCW-1:0]       cnt_ff, cnt_in;
   logic signed [loq_pkg::AW-1:0] a_ff, a_in;
   logic signed [loq_pkg::AW:0]   hi_ff, hi_in;
   logic [loq_pkg::BW-1:0]        lo_ff, lo_in;
   logic signed [loq_pkg::AW+1:0] sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   always_comb begin
      sum     = (loq_pkg::AW+2)'(hi_ff)
              + (lo_ff[0] ? (loq_pkg::AW+2)'(a_ff) : (loq_pkg::AW+2)'(0));
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = req.a;
         hi_in   = '0;
         lo_in   = req.b;
      end else if (busy_ff) begin
         // Add the multiplicand for this bit, then shift the pair right.
         hi_in  = sum[loq_pkg::AW+1:1];
         lo_in  = {sum[0], lo_ff[loq_pkg::BW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == loq_pkg::MCW'(loq_pkg::BW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = {hi_ff, lo_ff};

endmodule

// File: hdl/loq_div.sv
// Bit-serial restoring divider with floor or ceiling rounding by a positive divisor.
module loq_div (
   input  logic                 clock,
   input  logic                 reset,
   input  loq_pkg::div_req_type req,
   output loq_pkg::div_rsp_type rsp
);

   logic                          busy_ff, busy_in;
   logic                          fin_ff, fin_in;
   logic                          done_ff, done_in;
   logic [loq_pkg::DCW-1:0]       cnt_ff, cnt_in;
   logic [loq_pkg::DW-1:0]        rem_ff, rem_in;
   logic [loq_pkg::NW-1:0]        quo_ff, quo_in;
   logic [loq_pkg::DW-1:0]        d_ff, d_in;
   logic                          sign_ff, sign_in;
   logic                          pos_ff, pos_in;
   logic                          ceil_ff, ceil_in;
   logic                          zero_ff, zero_in;
   logic [loq_pkg::AW-1:0]        raw_ff, raw_in;
   logic signed [loq_pkg::AW-1:0] res_ff, res_in;
   logic [loq_pkg::DW:0]          trial;
   logic                          fits;
   logic [loq_pkg::NW-1:0]        mag;
   logic                          up;
   logic [loq_pkg::AW-1:0]        qmag;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      d_ff    <= d_in;
      sign_ff <= sign_in;
      pos_ff  <= pos_in;
      ceil_ff <= ceil_in;
      zero_ff <= zero_in;
      raw_ff  <= raw_in;
      res_ff  <= res_in;
   end

   always_comb begin
      trial   = {rem_ff, quo_ff[loq_pkg::NW-1]};
      fits    = trial >= {1'b0, d_ff};
      mag     = req.numer[loq_pkg::NW-1] ? loq_pkg::NW'(-req.numer)
                                         : loq_pkg::NW'(req.numer);
      // Round the magnitude up for a negative floor or a positive ceiling.
      up      = (rem_ff != '0) && ((!ceil_ff && sign_ff) || (ceil_ff && pos_ff));
      qmag    = quo_ff[loq_pkg::AW-1:0] + loq_pkg::AW'(up);
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      d_in    = d_ff;
      sign_in = sign_ff;
      pos_in  = pos_ff;
      ceil_in = ceil_ff;
      zero_in = zero_ff;
      raw_in  = raw_ff;
      res_in  = res_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = mag;
         d_in    = req.denom;
         sign_in = req.numer[loq_pkg::NW-1];
         pos_in  = !req.numer[loq_pkg::NW-1] && (req.numer != '0);
         ceil_in = req.ceil;
         zero_in = (req.denom == '0);
         raw_in  = req.numer[loq_pkg::AW-1:0];
      end else if (busy_ff) begin
         rem_in = fits ? loq_pkg::DW'(trial - {1'b0, d_ff}) : trial[loq_pkg::DW-1:0];
         quo_in = {quo_ff[loq_pkg::NW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == loq_pkg::DCW'(loq_pkg::NW-1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         // A zero divisor hands back the dividend.
         if (zero_ff) begin
            res_in = raw_ff;
         end else if (sign_ff) begin
            res_in = -qmag;
         end else begin
            res_in = qmag;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = res_ff;

endmodule

// File: hdl/line_octant_setup_and_query_core.sv
// Top level of the line octant setup and query core: registers, folding and query sequencer.
//
//   Channel  Direction  Handshake             Contents
//   req      in         req_tvalid/tready     tdata: coord; tuser: kind
//   rsp      out        rsp_tvalid/tready     tdata: value, last_x, last_y; tuser: flags
//   csr      in         csr_valid/csr_ready   csr_index, csr_data (one endpoint register)
//
// A query of the minor kind takes one multiplication and one division, the error term two
// multiplications and one division, and the major kind runs on the same bit-serial multiplier
// and bit-serial divider that every step shares; the major kind may need three of each.
// While a register write refolds the line, no beat is taken.
// Reset is synchronous and leaves the folded state of an all-zero line, far pixel (-1, 0).
// A new query beat is accepted while an earlier result still waits on a stalled rsp.
module line_octant_setup_and_query_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [loq_pkg::CW-1:0]   req_tdata,   // [15:0] coord
   input  logic [1:0]               req_tuser,   // [1:0] kind
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [3*loq_pkg::CW-1:0] rsp_tdata,   // [15:0] value, [31:16] last_x, [47:32] last_y
   output logic [1:0]               rsp_tuser,   // [0] x_is_major, [1] slope_negative
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [loq_pkg::CW-1:0]   csr_data
);

   localparam int CW = loq_pkg::CW;
   localparam int AW = loq_pkg::AW;
   localparam int TW = loq_pkg::TW;
   localparam int NW = loq_pkg::NW;
   localparam int DW = loq_pkg::DW;
   localparam int PW = loq_pkg::PW;

   loq_pkg::state_type state_ff, state_in;
   loq_pkg::phase_type phase_ff, phase_in;

   // Endpoint registers.
   logic signed [CW-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [CW-1:0] end_x_ff, end_x_in, end_y_ff, end_y_in;
   // Folded line.
   logic signed [CW-1:0] om_ff, om_in;
   logic signed [CW:0]   omn_ff, omn_in;
   logic [CW:0]          dmaj_ff, dmaj_in, dmin_ff, dmin_in;
   logic                 neg_ff, neg_in, mx_ff, mx_in;
   logic [CW-1:0]        lastx_ff, lastx_in, lasty_ff, lasty_in;
   // Query working registers.
   logic signed [AW-1:0] a_ff, a_in;
   logic                 bmaj_ff, bmaj_in;
   logic signed [TW-1:0] t_ff, t_in;
   logic [CW-1:0]        x_ff, x_in;
   logic signed [PW-1:0] p1_ff, p1_in;
   logic [CW-1:0]        val_ff, val_in;
   logic                 mul_go_ff, mul_go_in;
   logic                 div_go_ff, div_go_in;
   logic signed [NW-1:0] numer_ff, numer_in;
   logic [DW-1:0]        denom_ff, denom_in;
   logic                 ceil_ff, ceil_in;
   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [3*CW-1:0]      rsp_data_ff, rsp_data_in;
   logic [1:0]           rsp_user_ff, rsp_user_in;

   loq_pkg::mul_req_type mul_req;
   loq_pkg::mul_rsp_type mul_rsp;
   loq_pkg::div_req_type div_req;
   loq_pkg::div_rsp_type div_rsp;

   logic                 req_fire, csr_fire;
   logic signed [CW-1:0] c_s;
   // Folding terms.
   logic signed [CW:0]   dx, dy, d1, d2, d1n, d2n;
   logic [CW:0]          adx, ady;
   logic                 steep, swap, negn;
   logic signed [CW-1:0] aq, ap, bp, bq, mr, omf;
   logic signed [CW:0]   exf;
   // Division result terms.
   logic [CW-1:0]        q16, y16, ey16;

   assign req_fire = req_tvalid && req_tready;
   assign csr_fire = csr_valid && csr_ready;
   assign c_s      = $signed(req_tdata);

   assign req_tready = (state_ff == loq_pkg::ST_IDLE);
   assign csr_ready  = (state_ff == loq_pkg::ST_IDLE) && !req_tvalid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign mul_req.start = mul_go_ff;
   assign mul_req.a     = a_ff;
   assign mul_req.b     = bmaj_ff ? dmaj_ff : dmin_ff;
   assign div_req.start = div_go_ff;
   assign div_req.ceil  = ceil_ff;
   assign div_req.numer = numer_ff;
   assign div_req.denom = denom_ff;

   loq_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   loq_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= loq_pkg::ST_IDLE;
         phase_ff     <= loq_pkg::PH_SETUP_OFF;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
         om_ff        <= '0;
         omn_ff       <= '0;
         dmaj_ff      <= '0;
         dmin_ff      <= '0;
         neg_ff       <= 1'b0;
         mx_ff        <= 1'b1;
         lastx_ff     <= '1;
         lasty_ff     <= '0;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         end_x_ff     <= end_x_in;
         end_y_ff     <= end_y_in;
         om_ff        <= om_in;
         omn_ff       <= omn_in;
         dmaj_ff      <= dmaj_in;
         dmin_ff      <= dmin_in;
         neg_ff       <= neg_in;
         mx_ff        <= mx_in;
         lastx_ff     <= lastx_in;
         lasty_ff     <= lasty_in;
         mul_go_ff    <= mul_go_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      bmaj_ff     <= bmaj_in;
      t_ff        <= t_in;
      x_ff        <= x_in;
      p1_ff       <= p1_in;
      val_ff      <= val_in;
      numer_ff    <= numer_in;
      denom_ff    <= denom_in;
      ceil_ff     <= ceil_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Folding of the line into the first octant, from the endpoint registers.
   always_comb begin
      dx    = CW'(0) + ((CW+1)'(end_x_ff) - (CW+1)'(start_x_ff));
      dy    = (CW+1)'(end_y_ff) - (CW+1)'(start_y_ff);
      adx   = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
      ady   = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
      steep = ady > adx;
      ap    = steep ? start_y_ff : start_x_ff;
      aq    = steep ? end_y_ff : end_x_ff;
      bp    = steep ? start_x_ff : start_y_ff;
      bq    = steep ? end_x_ff : end_y_ff;
      d1    = steep ? dy : dx;
      d2    = steep ? dx : dy;
      swap  = d1[CW];
      omf   = swap ? aq : ap;
      mr    = swap ? bq : bp;
      d1n   = swap ? -d1 : d1;
      d2n   = swap ? -d2 : d2;
      negn  = d2n[CW];
      // The far end sits one step short of the second endpoint along the major axis.
      exf   = swap ? (CW+1)'(aq) + (CW+1)'(1) : (CW+1)'(aq) - (CW+1)'(1);
   end

   // Sequencer: next state and the working registers.
   always_comb begin
      q16  = div_rsp.quot[CW-1:0];
      y16  = q16 + omn_ff[CW-1:0];
      ey16 = neg_ff ? -y16 : y16;

      state_in   = state_ff;
      phase_in   = phase_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      end_x_in   = end_x_ff;
      end_y_in   = end_y_ff;
      om_in      = om_ff;
      omn_in     = omn_ff;
      dmaj_in    = dmaj_ff;
      dmin_in    = dmin_ff;
      neg_in     = neg_ff;
      mx_in      = mx_ff;
      lastx_in   = lastx_ff;
      lasty_in   = lasty_ff;
      a_in       = a_ff;
      bmaj_in    = bmaj_ff;
      t_in       = t_ff;
      x_in       = x_ff;
      p1_in      = p1_ff;
      val_in     = val_ff;
      mul_go_in  = 1'b0;
      div_go_in  = 1'b0;
      numer_in   = numer_ff;
      denom_in   = denom_ff;
      ceil_in    = ceil_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         loq_pkg::ST_IDLE: begin
            if (csr_fire) begin
               unique case (csr_index)
                  loq_pkg::REG_START_X: start_x_in = $signed(csr_data);
                  loq_pkg::REG_START_Y: start_y_in = $signed(csr_data);
                  loq_pkg::REG_END_X:   end_x_in   = $signed(csr_data);
                  loq_pkg::REG_END_Y:   end_y_in   = $signed(csr_data);
                  default:              end_y_in   = end_y_ff;
               endcase
               state_in = loq_pkg::ST_FOLD;
            end else if (req_fire) begin
               unique case (req_tuser)
                  loq_pkg::KIND_MINOR, loq_pkg::KIND_ERROR: begin
                     a_in      = AW'(c_s) - AW'(om_ff);
                     bmaj_in   = 1'b0;
                     phase_in  = (req_tuser == loq_pkg::KIND_MINOR) ? loq_pkg::PH_MINOR_OFF
                                                                   : loq_pkg::PH_ERR_OFF;
                     mul_go_in = 1'b1;
                     state_in  = loq_pkg::ST_MUL;
                  end
                  loq_pkg::KIND_MAJOR: begin
                     t_in      = (neg_ff ? -TW'(c_s) : TW'(c_s)) - TW'(omn_ff);
                     a_in      = AW'(t_in);
                     bmaj_in   = 1'b1;
                     phase_in  = loq_pkg::PH_MAJ_EST;
                     mul_go_in = 1'b1;
                     state_in  = loq_pkg::ST_MUL;
                  end
                  default: begin
                     // The unused kind answers zero.
                     val_in   = '0;
                     state_in = loq_pkg::ST_OUT;
                  end
               endcase
            end
         end

         loq_pkg::ST_FOLD: begin
            mx_in     = !steep;
            om_in     = omf;
            dmaj_in   = (CW+1)'(d1n);
            neg_in    = negn;
            dmin_in   = negn ? (CW+1)'(-d2n) : (CW+1)'(d2n);
            omn_in    = negn ? -(CW+1)'(mr) : (CW+1)'(mr);
            x_in      = exf[CW-1:0];
            a_in      = AW'(exf) - AW'(omf);
            bmaj_in   = 1'b0;
            phase_in  = loq_pkg::PH_SETUP_OFF;
            mul_go_in = 1'b1;
            state_in  = loq_pkg::ST_MUL;
         end

         loq_pkg::ST_MUL: begin
            if (mul_rsp.done) begin
               if (phase_ff == loq_pkg::PH_ERR_MUL) begin
                  // (2(x - origin) + 2) * minor delta - (2 * minor + 1) * major delta
                  val_in   = {p1_ff[CW-2:0], 1'b0} + {dmin_ff[CW-2:0], 1'b0}
                           - {mul_rsp.prod[CW-2:0], 1'b0} - dmaj_ff[CW-1:0];
                  state_in = loq_pkg::ST_OUT;
               end else begin
                  p1_in = mul_rsp.prod;
                  if (phase_ff == loq_pkg::PH_MAJ_EST) begin
                     numer_in = (NW'(mul_rsp.prod) <<< 1) - NW'(dmin_ff);
                     denom_in = {dmin_ff, 1'b0};
                     ceil_in  = 1'b1;
                  end else if (phase_ff == loq_pkg::PH_MAJ_BACK) begin
                     numer_in = (NW'(mul_rsp.prod) <<< 1) - NW'(dmaj_ff);
                     denom_in = {dmin_ff, 1'b0};
                     ceil_in  = 1'b1;
                  end else begin
                     numer_in = (NW'(mul_rsp.prod) <<< 1) + NW'(dmaj_ff);
                     denom_in = {dmaj_ff, 1'b0};
                     ceil_in  = 1'b0;
                  end
                  div_go_in = 1'b1;
                  state_in  = loq_pkg::ST_DIV;
               end
            end
         end

         loq_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               unique case (phase_ff)
                  loq_pkg::PH_SETUP_OFF: begin
                     lastx_in = mx_ff ? x_ff : ey16;
                     lasty_in = mx_ff ? ey16 : x_ff;
                     state_in = loq_pkg::ST_IDLE;
                  end
                  loq_pkg::PH_MINOR_OFF: begin
                     val_in   = ey16;
                     state_in = loq_pkg::ST_OUT;
                  end
                  loq_pkg::PH_MAJ_EST: begin
                     x_in = q16 + om_ff;
                     if (dmin_ff == '0) begin
                        val_in   = q16 + om_ff;
                        state_in = loq_pkg::ST_OUT;
                     end else begin
                        // Check the minor value of the position one step back.
                        a_in      = AW'($signed(q16)) - AW'(1);
                        bmaj_in   = 1'b0;
                        phase_in  = loq_pkg::PH_MAJ_CHECK;
                        mul_go_in = 1'b1;
                        state_in  = loq_pkg::ST_MUL;
                     end
                  end
                  loq_pkg::PH_MAJ_CHECK: begin
                     if (TW'($signed(q16)) == t_ff) begin
                        a_in      = div_rsp.quot;
                        bmaj_in   = 1'b1;
                        phase_in  = loq_pkg::PH_MAJ_BACK;
                        mul_go_in = 1'b1;
                        state_in  = loq_pkg::ST_MUL;
                     end else begin
                        val_in   = x_ff;
                        state_in = loq_pkg::ST_OUT;
                     end
                  end
                  loq_pkg::PH_MAJ_BACK: begin
                     val_in   = q16 + om_ff;
                     state_in = loq_pkg::ST_OUT;
                  end
                  loq_pkg::PH_ERR_OFF: begin
                     a_in      = AW'($signed(q16));
                     bmaj_in   = 1'b1;
                     phase_in  = loq_pkg::PH_ERR_MUL;
                     mul_go_in = 1'b1;
                     state_in  = loq_pkg::ST_MUL;
                  end
                  loq_pkg::PH_ERR_MUL: begin
                     state_in = loq_pkg::ST_OUT;
                  end
               endcase
            end
         end

         loq_pkg::ST_OUT: begin
            // Load the result register once the previous beat has gone.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {lasty_ff, lastx_ff, val_ff};
               rsp_user_in  = {neg_ff, mx_ff};
               state_in     = loq_pkg::ST_IDLE;
            end
         end

         default: state_in = loq_pkg::ST_IDLE;
      endcase
   end

   // A query is never taken in the same cycle as a register write.
   assert property (@(posedge clock) disable iff (reset) !(req_fire && csr_fire))
      else $error("query and register write accepted together");

   // The multiplier finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
                    mul_rsp.done |-> (state_ff == loq_pkg::ST_MUL))
      else $error("multiplier result with no waiting step");

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
                    div_rsp.done |-> (state_ff == loq_pkg::ST_DIV))
      else $error("divider result with no waiting step");

   // The folded minor delta never exceeds the major delta.
   assert property (@(posedge clock) disable iff (reset) dmin_ff <= dmaj_ff)
      else $error("folded line outside the first octant");

endmodule

// File: test/tb.sv
// Self-checking testbench of the line octant setup and query core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 3000;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] coord;
   } query_type;

   typedef struct {
      logic [15:0] value;
      logic [15:0] last_x;
      logic [15:0] last_y;
      logic        x_major;
      logic        slope_neg;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   line_octant_setup_and_query_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Endpoint registers and the folded line that the predictor keeps.
   logic [15:0] ep [4];
   longint org_maj, org_min, d_maj, d_min;
   bit     neg_slope, maj_x;
   logic [15:0] far_x, far_y;

   query_type  query_q [$];
   answer_type answer_q [$];
   int      fail_count = 0;
   bit      quiet_idle = 0;    // stretch in which neither side idles
   bit      hold_go = 0;       // asks the result side for its long hold-off
   bit      hold_seen = 0;     // the hold-off has been started
   int      hold_left = 0;     // cycles of hold-off still to run
   bit      stim_done = 0;
   int      idle_cycles = 0;

   function automatic longint wrap16(longint v);
      return longint'(signed'(v[15:0]));
   endfunction

   function automatic longint fdiv(longint n, longint d);
      if (d == 0) return n;
      if (d < 0) begin d = -d; n = -n; end
      if (n < 0) n -= d - 1;
      return n / d;
   endfunction

   function automatic longint cdiv(longint n, longint d);
      if (d == 0) return n;
      if (d < 0) begin d = -d; n = -n; end
      if (n > 0) n += d - 1;
      return n / d;
   endfunction

   function automatic longint minor_off(longint x);
      return fdiv(2 * (x - org_maj) * d_min + d_maj, 2 * d_maj);
   endfunction

   function automatic longint minor_of(longint x);
      longint y;
      y = wrap16(minor_off(x)) + org_min;
      return neg_slope ? -y : y;
   endfunction

   function automatic longint major_of(longint yq);
      longint t, x, v;
      t = (neg_slope ? -yq : yq) - org_min;
      x = wrap16(cdiv(2 * t * d_maj - d_min, 2 * d_min)) + org_maj;
      if (d_min != 0) begin
         v = minor_off(x - 1);
         if (wrap16(v) == t)
            x = org_maj + cdiv(2 * d_maj * v - d_maj, 2 * d_min);
      end
      return x;
   endfunction

   function automatic longint error_of(longint x);
      longint my;
      my = wrap16(minor_off(x));
      return (2 * (x - org_maj) + 2) * d_min - (2 * my + 1) * d_maj;
   endfunction

   // Folds the line into the first octant, as the block does after every write.
   task automatic fold_line();
      longint px, py, qx, qy, dx, dy, t, ex, ey;
      bit swapped;
      px = wrap16(ep[loq_pkg::REG_START_X]); py = wrap16(ep[loq_pkg::REG_START_Y]);
      qx = wrap16(ep[loq_pkg::REG_END_X]);   qy = wrap16(ep[loq_pkg::REG_END_Y]);
      dx = qx - px; dy = qy - py;
      swapped = 0; maj_x = 1; neg_slope = 0;
      if ((dy < 0 ? -dy : dy) > (dx < 0 ? -dx : dx)) begin
         maj_x = 0;
         t = px; px = py; py = t;
         t = qx; qx = qy; qy = t;
         t = dx; dx = dy; dy = t;
      end
      if (dx < 0) begin
         swapped = 1;
         t = px; px = qx; qx = t;
         t = py; py = qy; qy = t;
         dx = -dx; dy = -dy;
      end
      if (dy < 0) begin
         neg_slope = 1;
         dy = -dy; py = -py; qy = -qy;
      end
      d_min = dy; d_maj = dx; org_maj = px; org_min = py;
      ex = swapped ? px + 1 : qx - 1;
      ey = minor_of(ex);
      if (!maj_x) begin t = ex; ex = ey; ey = t; end
      far_x = ex[15:0];
      far_y = ey[15:0];
   endtask

   function automatic answer_type predict_answer(query_type q);
      answer_type a;
      longint c, v;
      c = wrap16(q.coord);
      case (q.kind)
         loq_pkg::KIND_MINOR: v = minor_of(c);
         loq_pkg::KIND_MAJOR: v = major_of(c);
         loq_pkg::KIND_ERROR: v = error_of(c);
         default:             v = 0;
      endcase
      a.value = v[15:0];
      a.last_x = far_x;
      a.last_y = far_y;
      a.x_major = maj_x;
      a.slope_neg = neg_slope;
      return a;
   endfunction

   // Driver: offers queued queries, idling now and then; predicts on acceptance.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            answer_q.push_back(predict_answer(query_q.pop_front()));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (query_q.size() != 0 && (quiet_idle || $urandom_range(99) >= 13)) begin
               req_tvalid <= 1'b1;
               req_tdata <= query_q[0].coord;
               req_tuser <= query_q[0].kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: accepts results with random stalls and compares each with the oldest prediction.
   // It also runs the long hold-off, counting its cycles itself.
   always @(posedge clock) begin
      answer_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               $display("%0t: unexpected result %h / %b", $time, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               e = answer_q.pop_front();
               if ({e.last_y, e.last_x, e.value} !== rsp_tdata
                   || {e.slope_neg, e.x_major} !== rsp_tuser) begin
                  $display("%0t: mismatch, expected data %h flags %b, got data %h flags %b",
                           $time, {e.last_y, e.last_x, e.value}, {e.slope_neg, e.x_major},
                           rsp_tdata, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (hold_go && !hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
         rsp_tready <= (hold_left == 0) && !(hold_go && !hold_seen)
                       && (quiet_idle || $urandom_range(99) >= 13);
      end
   end

   // Watchdog on cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready) || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   // Writes one endpoint register through the configuration channel and refolds the model.
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ep[idx] = val;
      fold_line();
   endtask

   task automatic wait_drained();
      while (query_q.size() != 0 || answer_q.size() != 0 || req_tvalid) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic set_line(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
      wait_drained();
      write_reg(loq_pkg::REG_START_X, a);
      write_reg(loq_pkg::REG_START_Y, b);
      write_reg(loq_pkg::REG_END_X, c);
      write_reg(loq_pkg::REG_END_Y, d);
   endtask

   task automatic push_query(logic [1:0] k, logic [15:0] c);
      query_type q;
      q.kind = k;
      q.coord = c;
      query_q.push_back(q);
   endtask

   initial begin
      logic [15:0] p0, p1;
      int seg;
      for (int i = 0; i < 4; i++) ep[i] = '0;
      fold_line();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: the degenerate reset line first, including the unused kind.
      quiet_idle = 1;
      for (int k = 0; k < 4; k++) push_query(2'(k), 16'd3);
      push_query(loq_pkg::KIND_MINOR, 16'h8000);
      push_query(loq_pkg::KIND_MAJOR, 16'h7fff);
      // Steep line with positive slope and swapped endpoints, then the widest line.
      set_line(16'd10, 16'd50, 16'd3, -16'd20);
      for (int k = 0; k < 4; k++) push_query(2'(k), 16'd5);
      push_query(loq_pkg::KIND_MAJOR, 16'hffff);
      push_query(loq_pkg::KIND_ERROR, 16'h8000);
      set_line(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      for (int k = 0; k < 3; k++) begin
         push_query(2'(k), 16'h8000);
         push_query(2'(k), 16'h7fff);
      end
      set_line(16'd0, 16'd0, 16'd7, 16'd0);    // horizontal: no minor delta
      for (int k = 0; k < 3; k++) push_query(2'(k), 16'd2);

      // Long hold-off on the result side while queries keep arriving.
      wait_drained();
      hold_go = 1;
      for (int i = 0; i < 20; i++) push_query(2'($urandom_range(2)), rand_coord());
      wait (hold_seen && hold_left == 0);
      quiet_idle = 0;

      // Random: new lines between phases, mostly valid kinds, many near the start point.
      for (seg = 0; seg < 36; seg++) begin
         p0 = rand_coord();
         p1 = rand_coord();
         if (seg % 3 == 0)
            set_line(p0, p1, p0 + 16'($urandom_range(40)) - 16'd20,
                     p1 + 16'($urandom_range(40)) - 16'd20);
         else
            set_line(p0, p1, rand_coord(), rand_coord());
         quiet_idle = (seg == 10);
         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(9) == 0)
               push_query(2'($urandom_range(3)), rand_coord());
            else if ($urandom_range(1))
               push_query(2'($urandom_range(2)), p0 + 16'($urandom_range(64)) - 16'd32);
            else
               push_query(2'($urandom_range(2)), rand_coord());
         end
      end
      wait_drained();
      stim_done = 1;
      if (fail_count == 0 && answer_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
